>>> rtl/core/nrcenc_pkg.sv
// nrcenc_pkg: shared types and constants for the IR frame encoder core.
// Request codes, register indexes, reset values, config and result structs.
// No dependencies.
package nrcenc_pkg;

	localparam int CODE_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SEND   = 2'd1,
		OP_REPEAT = 2'd2,
		OP_STOP   = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_START_STOP_WORD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TIME    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_GAP_TIME     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GAP_TICKS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_GAP_TICKS   = 3'd5;

	localparam logic [15:0] RST_START_STOP_WORD  = 16'hFEFF;
	localparam logic [4:0]  RST_FRAME_BITS       = 5'd16;
	localparam logic [7:0]  RST_HALF_BIT_TIME    = 8'd19;
	localparam logic [7:0]  RST_PRE_GAP_TIME     = 8'd95;
	localparam logic [7:0]  RST_REPEAT_GAP_TICKS = 8'd156;
	localparam logic [7:0]  RST_SEND_GAP_TICKS   = 8'd38;
	localparam logic [7:0]  RST_GAP_LIMIT        = 8'd19;

	typedef struct packed {
		logic [15:0] start_stop_word;
		logic [4:0]  frame_bits;
		logic [7:0]  half_bit_time;
		logic [7:0]  pre_gap_time;
		logic [7:0]  repeat_gap_ticks;
		logic [7:0]  send_gap_ticks;
	} cfg_t;

	typedef struct packed {
		op_t               op;
		logic [CODE_W-1:0] send_code;
	} item_t;

	typedef struct packed {
		logic       carrier_on;
		logic [7:0] tick_period;
		logic       busy;
	} res_t;

endpackage

>>> rtl/core/nrcenc_cfg.sv
// nrcenc_cfg: configuration register file, write-only, reset to defaults.
// Depends on nrcenc_pkg.
module nrcenc_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [nrcenc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [nrcenc_pkg::CFG_DATA_W-1:0]   wr_data,
	output nrcenc_pkg::cfg_t                    cfg
);

	nrcenc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_stop_word  <= nrcenc_pkg::RST_START_STOP_WORD;
			cfg_q.frame_bits       <= nrcenc_pkg::RST_FRAME_BITS;
			cfg_q.half_bit_time    <= nrcenc_pkg::RST_HALF_BIT_TIME;
			cfg_q.pre_gap_time     <= nrcenc_pkg::RST_PRE_GAP_TIME;
			cfg_q.repeat_gap_ticks <= nrcenc_pkg::RST_REPEAT_GAP_TICKS;
			cfg_q.send_gap_ticks   <= nrcenc_pkg::RST_SEND_GAP_TICKS;
		end else if (wr_en) begin
			unique case (wr_index)
				nrcenc_pkg::REG_START_STOP_WORD:  cfg_q.start_stop_word  <= wr_data;
				nrcenc_pkg::REG_FRAME_BITS:       cfg_q.frame_bits       <= wr_data[4:0];
				nrcenc_pkg::REG_HALF_BIT_TIME:    cfg_q.half_bit_time    <= wr_data[7:0];
				nrcenc_pkg::REG_PRE_GAP_TIME:     cfg_q.pre_gap_time     <= wr_data[7:0];
				nrcenc_pkg::REG_REPEAT_GAP_TICKS: cfg_q.repeat_gap_ticks <= wr_data[7:0];
				nrcenc_pkg::REG_SEND_GAP_TICKS:   cfg_q.send_gap_ticks   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/nrcenc_fsm.sv
// nrcenc_fsm: frame sequencer; one request per enabled cycle updates phase,
// shift word, counters and the carrier gate / period outputs.
// Depends on nrcenc_pkg.
module nrcenc_fsm #(
	parameter int WORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  nrcenc_pkg::item_t  item,
	input  nrcenc_pkg::cfg_t   cfg,
	output nrcenc_pkg::res_t   res
);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_PRE_ON     = 3'd1,
		PH_PRE_OFF    = 3'd2,
		PH_START_ON   = 3'd3,
		PH_START_OFF  = 3'd4,
		PH_BIT_FIRST  = 3'd5,
		PH_BIT_SECOND = 3'd6,
		PH_GAP        = 3'd7
	} phase_t;

	phase_t                            phase_q, phase_d;
	logic [WORD_BITS-1:0]              shift_q, shift_d;
	logic [nrcenc_pkg::CODE_W-1:0]     code_q, code_d;
	logic [4:0]                        bit_cnt_q, bit_cnt_d, bit_inc;
	logic [7:0]                        gap_cnt_q, gap_cnt_d, gap_inc;
	logic [7:0]                        gap_lim_q, gap_lim_d;
	logic                              gate_q, gate_d;
	logic [7:0]                        period_q, period_d;
	logic                              stop_pend_q, stop_pend_d;

	logic [WORD_BITS+15:0] ssw_ext, code_ext;

	assign ssw_ext  = {{WORD_BITS{1'b0}}, cfg.start_stop_word};
	assign code_ext = {{WORD_BITS{1'b0}}, code_q};
	assign bit_inc  = bit_cnt_q + 5'd1;
	assign gap_inc  = gap_cnt_q + 8'd1;

	always_comb begin
		phase_d     = phase_q;
		shift_d     = shift_q;
		code_d      = code_q;
		bit_cnt_d   = bit_cnt_q;
		gap_cnt_d   = gap_cnt_q;
		gap_lim_d   = gap_lim_q;
		gate_d      = gate_q;
		period_d    = period_q;
		stop_pend_d = stop_pend_q;
		unique case (item.op)
			nrcenc_pkg::OP_TICK: begin
				unique case (phase_q)
					PH_PRE_ON: begin
						period_d = cfg.half_bit_time;
						gate_d   = 1'b1;
						phase_d  = PH_PRE_OFF;
					end
					PH_START_ON: begin
						period_d = cfg.half_bit_time;
						gate_d   = 1'b1;
						phase_d  = PH_START_OFF;
					end
					PH_PRE_OFF: begin
						period_d = cfg.pre_gap_time;
						gate_d   = 1'b0;
						phase_d  = PH_START_ON;
					end
					PH_START_OFF: begin
						period_d = cfg.half_bit_time;
						gate_d   = 1'b0;
						phase_d  = PH_BIT_FIRST;
					end
					PH_BIT_FIRST: begin
						gate_d  = shift_q[0];
						shift_d = shift_q >> 1;
						phase_d = PH_BIT_SECOND;
					end
					PH_BIT_SECOND: begin
						gate_d    = ~gate_q;
						bit_cnt_d = bit_inc;
						phase_d   = (bit_inc == cfg.frame_bits) ? PH_GAP : PH_BIT_FIRST;
					end
					PH_GAP: begin
						gate_d    = 1'b0;
						gap_cnt_d = gap_inc;
						period_d  = cfg.half_bit_time;
						if (gap_inc >= gap_lim_q) begin
							bit_cnt_d = '0;
							gap_cnt_d = '0;
							gap_lim_d = cfg.pre_gap_time;
							phase_d   = PH_IDLE;
							if (stop_pend_q) begin
								shift_d     = ssw_ext[WORD_BITS-1:0];
								phase_d     = PH_PRE_ON;
								code_d      = '0;
								stop_pend_d = 1'b0;
							end
						end
					end
					PH_IDLE: begin
						gate_d = 1'b0;
						if (stop_pend_q) begin
							shift_d     = ssw_ext[WORD_BITS-1:0];
							phase_d     = PH_PRE_ON;
							code_d      = '0;
							stop_pend_d = 1'b0;
						end
					end
					default: ;
				endcase
			end
			nrcenc_pkg::OP_SEND: begin
				code_d = item.send_code;
				if (item.send_code != '0 && phase_q == PH_IDLE) begin
					gap_lim_d = cfg.send_gap_ticks;
					shift_d   = ssw_ext[WORD_BITS-1:0];
					phase_d   = PH_PRE_ON;
				end
			end
			nrcenc_pkg::OP_REPEAT: begin
				if (code_q != '0 && phase_q == PH_IDLE) begin
					gap_lim_d = cfg.repeat_gap_ticks;
					shift_d   = code_ext[WORD_BITS-1:0];
					phase_d   = PH_PRE_ON;
				end
			end
			nrcenc_pkg::OP_STOP: begin
				if (code_q != '0) begin
					if (phase_q == PH_IDLE) begin
						shift_d     = ssw_ext[WORD_BITS-1:0];
						phase_d     = PH_PRE_ON;
						code_d      = '0;
						stop_pend_d = 1'b0;
					end else begin
						stop_pend_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			code_q      <= '0;
			bit_cnt_q   <= '0;
			gap_cnt_q   <= '0;
			gap_lim_q   <= nrcenc_pkg::RST_GAP_LIMIT;
			gate_q      <= 1'b0;
			period_q    <= '0;
			stop_pend_q <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			shift_q     <= shift_d;
			code_q      <= code_d;
			bit_cnt_q   <= bit_cnt_d;
			gap_cnt_q   <= gap_cnt_d;
			gap_lim_q   <= gap_lim_d;
			gate_q      <= gate_d;
			period_q    <= period_d;
			stop_pend_q <= stop_pend_d;
		end
	end

	// state registers double as the result register
	assign res.carrier_on  = gate_q;
	assign res.tick_period = period_q;
	assign res.busy        = (phase_q != PH_IDLE);

endmodule

>>> rtl/core/nrc17_ir_frame_encoder_core.sv
// nrc17_ir_frame_encoder_core: IR frame encoder, stream in / stream out.
// A beat accepted into the input register yields its result beat when it advances
// into the sequencer registers. Throughput: one beat per cycle while m_tready is high;
// the input register and the sequencer registers form two stages, each with a single update per beat.
// Reset (arst_n low, async): idle phase, no stored code, registers at defaults.
// Depends on nrcenc_pkg, nrcenc_cfg, nrcenc_fsm.
module nrc17_ir_frame_encoder_core #(
	parameter int WORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [15:0]                         s_tdata,   // [15:0] send_code
	input  logic [1:0]                          s_tuser,   // [1:0] op
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [15:0]                         m_tdata,   // [0] carrier_on, [8:1] tick_period,
	                                                       // [9] busy_res, [15:10] zero
	input  logic                                cfg_wr_en,
	input  logic [nrcenc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [nrcenc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic              valid_s1;
	nrcenc_pkg::item_t item_s1;
	logic              out_valid_q;
	logic              advance;
	nrcenc_pkg::cfg_t  cfg;
	nrcenc_pkg::res_t  res;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op        <= nrcenc_pkg::op_t'(s_tuser);
			item_s1.send_code <= s_tdata;
		end
	end

	nrcenc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_wr_en),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	nrcenc_fsm #(
		.WORD_BITS (WORD_BITS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, res.busy, res.tick_period, res.carrier_on};

`ifndef SYNTH
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled beat");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed beat produced no result");

	a_idle_gate: assert property (@(posedge clk) disable iff (!arst_n)
		!res.busy |-> !res.carrier_on)
		else $error("carrier gated on while idle");
`endif

endmodule

>>> tb/nrcenc_frame_checker.sv
// nrcenc_frame_checker: scoreboard for the IR frame encoder core.
// Tracks register writes, predicts one result beat per request beat and compares.
// Depends on nrcenc_pkg.
module nrcenc_frame_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // [15:0] send_code
	input  logic [1:0]                        s_tuser,   // [1:0] op
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [15:0]                       m_tdata,   // [0] carrier_on, [8:1] tick_period, [9] busy_res
	input  logic                              cfg_wr_en,
	input  logic [nrcenc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nrcenc_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                fail_count,
	output int                                pending,
	output int                                results_seen,
	output int                                frames_started
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_LEAD_ON, SEQ_LEAD_OFF, SEQ_START_ON,
		SEQ_START_OFF, SEQ_HALF_A, SEQ_HALF_B, SEQ_GAP
	} seq_t;

	nrcenc_pkg::cfg_t              regs;
	seq_t                          seq;
	logic [nrcenc_pkg::CODE_W-1:0] word_sr;
	logic [nrcenc_pkg::CODE_W-1:0] stored_code;
	logic [4:0]                    bits_out;
	logic [7:0]                    gap_ticks;
	logic [7:0]                    gap_end;
	logic                          gate;
	logic [7:0]                    reload;
	logic                          stop_held;
	nrcenc_pkg::res_t              expected_beats[$];

	task automatic launch_word(input logic [nrcenc_pkg::CODE_W-1:0] word);
		word_sr = word;
		seq = SEQ_LEAD_ON;
		frames_started++;
	endtask

	task automatic launch_stop_word();
		launch_word(regs.start_stop_word);
		stored_code = '0;
		stop_held = 1'b0;
	endtask

	task automatic timer_tick();
		case (seq)
			SEQ_LEAD_ON, SEQ_START_ON: begin
				reload = regs.half_bit_time;
				gate = 1'b1;
				seq = (seq == SEQ_LEAD_ON) ? SEQ_LEAD_OFF : SEQ_START_OFF;
			end
			SEQ_LEAD_OFF: begin
				reload = regs.pre_gap_time;
				gate = 1'b0;
				seq = SEQ_START_ON;
			end
			SEQ_START_OFF: begin
				reload = regs.half_bit_time;
				gate = 1'b0;
				seq = SEQ_HALF_A;
			end
			SEQ_HALF_A: begin
				gate = word_sr[0];
				word_sr = word_sr >> 1;
				seq = SEQ_HALF_B;
			end
			SEQ_HALF_B: begin
				gate = ~gate;
				bits_out = bits_out + 5'd1;
				seq = (bits_out == regs.frame_bits) ? SEQ_GAP : SEQ_HALF_A;
			end
			SEQ_GAP: begin
				gate = 1'b0;
				gap_ticks = gap_ticks + 8'd1;
				reload = regs.half_bit_time;
				if (gap_ticks >= gap_end) begin
					bits_out = '0;
					gap_ticks = '0;
					gap_end = regs.pre_gap_time;
					seq = SEQ_IDLE;
					if (stop_held)
						launch_stop_word();
				end
			end
			default: begin
				gate = 1'b0;
				if (stop_held)
					launch_stop_word();
			end
		endcase
	endtask

	task automatic encoder_step(input nrcenc_pkg::op_t op,
		input logic [nrcenc_pkg::CODE_W-1:0] code, output nrcenc_pkg::res_t r);
		case (op)
			nrcenc_pkg::OP_TICK: timer_tick();
			nrcenc_pkg::OP_SEND: begin
				stored_code = code;
				if (stored_code != '0 && seq == SEQ_IDLE) begin
					gap_end = regs.send_gap_ticks;
					launch_word(regs.start_stop_word);
				end
			end
			nrcenc_pkg::OP_REPEAT: begin
				if (stored_code != '0 && seq == SEQ_IDLE) begin
					gap_end = regs.repeat_gap_ticks;
					launch_word(stored_code);
				end
			end
			default: begin
				if (stored_code != '0) begin
					if (seq == SEQ_IDLE)
						launch_stop_word();
					else
						stop_held = 1'b1;
				end
			end
		endcase
		r.carrier_on = gate;
		r.tick_period = reload;
		r.busy = (seq != SEQ_IDLE);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		nrcenc_pkg::res_t want;
		nrcenc_pkg::res_t pred;
		if (!arst_n) begin
			regs.start_stop_word <= nrcenc_pkg::RST_START_STOP_WORD;
			regs.frame_bits <= nrcenc_pkg::RST_FRAME_BITS;
			regs.half_bit_time <= nrcenc_pkg::RST_HALF_BIT_TIME;
			regs.pre_gap_time <= nrcenc_pkg::RST_PRE_GAP_TIME;
			regs.repeat_gap_ticks <= nrcenc_pkg::RST_REPEAT_GAP_TICKS;
			regs.send_gap_ticks <= nrcenc_pkg::RST_SEND_GAP_TICKS;
			seq = SEQ_IDLE;
			word_sr = '0;
			stored_code = '0;
			bits_out = '0;
			gap_ticks = '0;
			gap_end = nrcenc_pkg::RST_GAP_LIMIT;
			gate = 1'b0;
			reload = '0;
			stop_held = 1'b0;
			expected_beats.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_beats.size() == 0) begin
					$error("result beat %h arrived with nothing expected", m_tdata);
					fail_count++;
				end else begin
					want = expected_beats.pop_front();
					if (m_tdata[0] !== want.carrier_on) begin
						$error("carrier_on expected %0d got %0d", want.carrier_on, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[8:1] !== want.tick_period) begin
						$error("tick_period expected %0d got %0d", want.tick_period, m_tdata[8:1]);
						fail_count++;
					end
					if (m_tdata[9] !== want.busy) begin
						$error("busy_res expected %0d got %0d", want.busy, m_tdata[9]);
						fail_count++;
					end
					if (m_tdata[15:10] !== 6'd0) begin
						$error("m_tdata pad expected 0 got %0h", m_tdata[15:10]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				encoder_step(nrcenc_pkg::op_t'(s_tuser), s_tdata, pred);
				expected_beats.push_back(pred);
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					nrcenc_pkg::REG_START_STOP_WORD:  regs.start_stop_word <= cfg_data;
					nrcenc_pkg::REG_FRAME_BITS:       regs.frame_bits <= cfg_data[4:0];
					nrcenc_pkg::REG_HALF_BIT_TIME:    regs.half_bit_time <= cfg_data[7:0];
					nrcenc_pkg::REG_PRE_GAP_TIME:     regs.pre_gap_time <= cfg_data[7:0];
					nrcenc_pkg::REG_REPEAT_GAP_TICKS: regs.repeat_gap_ticks <= cfg_data[7:0];
					nrcenc_pkg::REG_SEND_GAP_TICKS:   regs.send_gap_ticks <= cfg_data[7:0];
					default: ;
				endcase
			end
			pending = expected_beats.size();
		end
	end

endmodule

>>> tb/nrc17_ir_frame_encoder_core_tb.sv
// nrc17_ir_frame_encoder_core_tb: stimulus and verdict for the IR frame encoder core.
// Drives requests, register settings and output stalls; checking is in nrcenc_frame_checker.
// Depends on nrcenc_pkg, nrc17_ir_frame_encoder_core, nrcenc_frame_checker.
module nrc17_ir_frame_encoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 60;
	localparam int PHASE_BEATS = 300;
	localparam int NUM_SETTINGS = 5;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [15:0]                       s_tdata = '0;
	logic [1:0]                        s_tuser = nrcenc_pkg::OP_TICK;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [15:0]                       m_tdata;
	logic                              cfg_wr_en = 1'b0;
	logic [nrcenc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [nrcenc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int results_seen;
	int frames_started;
	int items_sent = 0;
	bit idle_en = 1'b1;
	bit hold_off = 1'b0;

	always #2 clk = ~clk;

	nrc17_ir_frame_encoder_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nrcenc_frame_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_seen   (results_seen),
		.frames_started (frames_started)
	);

	task automatic push(input nrcenc_pkg::op_t op, input logic [15:0] code);
		int gap;
		if (idle_en && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= code;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic run_ticks(input int count);
		repeat (count) push(nrcenc_pkg::OP_TICK, 16'($urandom_range(0, 16'hFFFF)));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_regs(input nrcenc_pkg::cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= nrcenc_pkg::REG_START_STOP_WORD;
		cfg_data <= c.start_stop_word;
		@(negedge clk);
		cfg_index <= nrcenc_pkg::REG_FRAME_BITS;
		cfg_data <= nrcenc_pkg::CFG_DATA_W'(c.frame_bits);
		@(negedge clk);
		cfg_index <= nrcenc_pkg::REG_HALF_BIT_TIME;
		cfg_data <= nrcenc_pkg::CFG_DATA_W'(c.half_bit_time);
		@(negedge clk);
		cfg_index <= nrcenc_pkg::REG_PRE_GAP_TIME;
		cfg_data <= nrcenc_pkg::CFG_DATA_W'(c.pre_gap_time);
		@(negedge clk);
		cfg_index <= nrcenc_pkg::REG_REPEAT_GAP_TICKS;
		cfg_data <= nrcenc_pkg::CFG_DATA_W'(c.repeat_gap_ticks);
		@(negedge clk);
		cfg_index <= nrcenc_pkg::REG_SEND_GAP_TICKS;
		cfg_data <= nrcenc_pkg::CFG_DATA_W'(c.send_gap_ticks);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// request beat followed by a run of ticks, mostly a long run that may or may not finish a frame
	task automatic random_phase(input int quota, input int hold_at, input int pause_at);
		int n;
		int len;
		nrcenc_pkg::op_t op;
		logic [15:0] code;
		n = 0;
		while (n < quota) begin
			if (hold_at >= 0 && n >= hold_at) begin
				hold_off = 1'b1;
				hold_at = -1;
			end
			if (pause_at >= 0 && n >= pause_at) begin
				drain();
				pause_at = -1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: op = nrcenc_pkg::OP_SEND;
				4, 5, 6, 7: op = nrcenc_pkg::OP_REPEAT;
				8: op = nrcenc_pkg::OP_STOP;
				default: op = nrcenc_pkg::op_t'($urandom_range(0, 3));
			endcase
			case ($urandom_range(0, 9))
				0: code = 16'h0000;
				1: code = 16'hFFFF;
				2: code = 16'h0001 << $urandom_range(0, 15);
				default: code = 16'($urandom_range(0, 16'hFFFF));
			endcase
			push(op, code);
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(10, 90);
			run_ticks(len);
			n += len + 1;
		end
	endtask

	initial begin : rx
		int stall;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
				m_tready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 11) == 0) begin
				stall = $urandom_range(1, 12);
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : stim
		nrcenc_pkg::cfg_t settings[NUM_SETTINGS];
		settings[0] = '{start_stop_word: 16'h0000, frame_bits: 5'd1, half_bit_time: 8'd1,
			pre_gap_time: 8'd1, repeat_gap_ticks: 8'd0, send_gap_ticks: 8'd0};
		settings[1] = '{start_stop_word: 16'hFFFF, frame_bits: 5'd16, half_bit_time: 8'd255,
			pre_gap_time: 8'd255, repeat_gap_ticks: 8'd255, send_gap_ticks: 8'd255};
		settings[2] = '{start_stop_word: 16'h8001, frame_bits: 5'd0, half_bit_time: 8'd7,
			pre_gap_time: 8'd200, repeat_gap_ticks: 8'd3, send_gap_ticks: 8'd5};
		settings[3] = '{start_stop_word: 16'($urandom_range(0, 16'hFFFF)), frame_bits: 5'd20,
			half_bit_time: 8'($urandom_range(1, 255)), pre_gap_time: 8'($urandom_range(1, 20)),
			repeat_gap_ticks: 8'($urandom_range(0, 20)), send_gap_ticks: 8'($urandom_range(0, 20))};
		settings[4] = '{start_stop_word: 16'($urandom_range(0, 16'hFFFF)),
			frame_bits: 5'($urandom_range(1, 16)), half_bit_time: 8'($urandom_range(1, 255)),
			pre_gap_time: 8'($urandom_range(1, 40)), repeat_gap_ticks: 8'($urandom_range(0, 40)),
			send_gap_ticks: 8'($urandom_range(0, 40))};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no stored code yet, then a frame with requests landing while busy
		push(nrcenc_pkg::OP_TICK, 16'h0000);
		push(nrcenc_pkg::OP_REPEAT, 16'hFFFF);
		push(nrcenc_pkg::OP_STOP, 16'h0000);
		push(nrcenc_pkg::OP_SEND, 16'h0000);
		push(nrcenc_pkg::OP_SEND, 16'h0001);
		run_ticks(3);
		push(nrcenc_pkg::OP_SEND, 16'hFFFF);
		push(nrcenc_pkg::OP_REPEAT, 16'h1234);
		push(nrcenc_pkg::OP_STOP, 16'h0000);
		run_ticks(12);
		drain();

		random_phase(250, -1, 120);
		for (int k = 0; k < NUM_SETTINGS; k++) begin
			drain();
			write_regs(settings[k]);
			idle_en = (k != NUM_SETTINGS - 1);
			random_phase(PHASE_BEATS, (k == 0) ? 100 : -1, -1);
		end

		drain();
		repeat (8) @(negedge clk);
		$display("Sent %0d request beats under the reset setting and %0d written settings.",
			items_sent, NUM_SETTINGS);
		$display("Checked %0d result beats covering %0d launched frames.",
			results_seen, frames_started);
		if (fail_count == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin : watchdog
		#1600000;
		$display("Mismatches found");
		$finish;
	end

endmodule
